// File: sv/hrbi_pkg.sv
// Shared constants and types for the heart-rate-from-beat-intervals block.
// Used by the ring, the serial divider instances and the top level; no dependencies.
package hrbi_pkg;

  localparam int IvW = 16;                 // interval width in ms
  localparam int BpmW = 8;                 // heart rate width
  localparam int AvgW = 12;                // averaged rate times 16

  localparam logic [1:0] RING_DEPTH = 2'd3;

  localparam logic [IvW-1:0] MS_PER_MIN = 16'd60000;
  localparam logic [BpmW-1:0] MAX_BPM = 8'd250;

  // interval * 1024 / 1000 equals (interval << 7) / 125 exactly.
  localparam int RrShift = 7;
  localparam int RrDivW = 7;
  localparam logic [RrDivW-1:0] RR_DIVISOR = 7'd125;

  localparam logic [AvgW:0] ROUND_HALF = 13'd8;

  // Ring update request from the sequencer.
  typedef struct packed {
    logic clr;
    logic wr;
    logic [IvW-1:0] data;
  } ring_ctl_t;

endpackage

// File: sv/hrbi_serdiv.sv
// Restoring divider that retires one quotient bit per cycle.
// Depends on nothing; instantiated twice by the top level.
module hrbi_serdiv #(
  parameter int DW = 16,
  parameter int VW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo;
  logic [VW-1:0] rem;
  logic [VW-1:0] dsr;
  logic [CW-1:0] cnt;
  logic          run;
  logic [VW:0]   part;
  logic [VW:0]   diff;

  // The partial remainder stays below the divisor, so one extra bit covers the shift.
  assign part = {rem, quo[DW-1]};
  assign diff = part - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      run  <= 1'b1;
      done <= 1'b0;
      cnt  <= CW'(DW);
    end else if (run) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (run) begin
      if (diff[VW]) begin
        rem <= part[VW-1:0];
        quo <= {quo[DW-2:0], 1'b0};
      end else begin
        rem <= diff[VW-1:0];
        quo <= {quo[DW-2:0], 1'b1};
      end
    end
  end

  assign quotient = quo;

endmodule

// File: sv/hrbi_ring.sv
// Three-entry interval history with fill count and median selection.
// Depends on hrbi_pkg for the ring control struct and depth.
module hrbi_ring (
  input  logic                      clk,
  input  logic                      rst,
  input  hrbi_pkg::ring_ctl_t       ctl,
  output logic [hrbi_pkg::IvW-1:0]  basis
);
  import hrbi_pkg::*;

  logic [IvW-1:0] ring [3];
  logic [IvW-1:0] last;
  logic [1:0]     fill;
  logic [1:0]     slot;
  logic [IvW-1:0] lo;
  logic [IvW-1:0] hi;
  logic [IvW-1:0] med;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      slot <= '0;
    end else if (ctl.clr) begin
      fill <= '0;
      slot <= '0;
    end else if (ctl.wr) begin
      slot <= (slot == RING_DEPTH - 2'd1) ? 2'd0 : slot + 2'd1;
      if (fill != RING_DEPTH) begin
        fill <= fill + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr && !ctl.clr) begin
      ring[slot] <= ctl.data;
      last       <= ctl.data;
    end
  end

  always_comb begin
    lo = (ring[0] < ring[1]) ? ring[0] : ring[1];
    hi = (ring[0] < ring[1]) ? ring[1] : ring[0];
    priority if (ring[2] <= lo) begin
      med = lo;
    end else if (ring[2] >= hi) begin
      med = hi;
    end else begin
      med = ring[2];
    end
  end

  // Until three intervals are held, the newest one stands alone.
  assign basis = (fill == RING_DEPTH) ? med : last;

endmodule

// File: sv/heart_rate_from_beat_intervals.sv
// Heart rate from beat intervals: median-of-three, 60000/x rate, EMA with alpha 1/4.
// Flow: a nonzero interval passes S_START, S_DIV and S_EMA, then m_tvalid is registered;
// a zero interval only clears the history and produces nothing. The next interval is
// taken after S_EMA commits, the wait set by the bit-serial divide forming 1/1024 s units.
// Reset (rst, synchronous, active high) empties the history and unseeds the average.
// Depends on hrbi_pkg, hrbi_ring and hrbi_serdiv.
module heart_rate_from_beat_intervals (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] interval_ms
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [7:0] heart_rate_bpm, [23:8] last_interval_ms,
                                 // [39:24] rr_units
);
  import hrbi_pkg::*;

  localparam int RrDW = IvW + RrShift;

  // One-hot sequencer: one interval is in flight at a time.
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_DIV   = 5'b00100,
    S_EMA   = 5'b01000,
    S_SPARE = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic [IvW-1:0]  iv;
  ring_ctl_t       ring_ctl;
  logic [IvW-1:0]  basis;
  logic            div_start;
  logic            rate_done;
  logic            rr_done;
  logic [IvW-1:0]  rate_q;
  logic [RrDW-1:0] rr_q;

  logic [AvgW-1:0] avg;
  logic [AvgW-1:0] avg_next;
  logic [BpmW-1:0] bpm;
  logic [AvgW-1:0] x16;
  logic [AvgW:0]   diff;
  logic [AvgW:0]   step;
  logic [AvgW:0]   avg_sum;
  logic [AvgW:0]   rounded;
  logic            in_xfer;
  logic            out_free;
  logic            commit;

  assign s_tready = (state == S_IDLE);
  assign in_xfer  = s_tvalid && s_tready;

  // The output register frees up in the same cycle its transfer completes.
  assign out_free = !m_tvalid || m_tready;
  assign commit   = (state == S_EMA) && out_free;

  // A zero interval only clears the history; anything else is written to it.
  assign ring_ctl.clr  = in_xfer && (s_tdata == '0);
  assign ring_ctl.wr   = in_xfer && (s_tdata != '0);
  assign ring_ctl.data = s_tdata;

  hrbi_ring u_ring (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ring_ctl),
    .basis (basis)
  );

  // Both divides start together once the ring has settled on the basis.
  assign div_start = (state == S_START);

  hrbi_serdiv #(
    .DW (IvW),
    .VW (IvW)
  ) u_rate_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (MS_PER_MIN),
    .divisor  (basis),
    .done     (rate_done),
    .quotient (rate_q)
  );

  hrbi_serdiv #(
    .DW (RrDW),
    .VW (RrDivW)
  ) u_rr_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({iv, RrShift'(0)}),
    .divisor  (RR_DIVISOR),
    .done     (rr_done),
    .quotient (rr_q)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (ring_ctl.wr) begin
          state_next = S_START;
        end
      end
      S_START: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        if (rate_done && rr_done) begin
          state_next = S_EMA;
        end
      end
      S_EMA: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_ctl.wr) begin
      iv <= s_tdata;
    end
  end

  // Rate is clamped to the top of the range, then scaled by 16 for the average.
  assign bpm = (rate_q > IvW'(MAX_BPM)) ? MAX_BPM : rate_q[BpmW-1:0];
  assign x16 = {bpm, 4'b0000};

  // Signed step of a quarter of the difference, truncated toward zero:
  // a negative difference is biased by three before the arithmetic shift.
  always_comb begin
    diff = {1'b0, x16} - {1'b0, avg};
    if (diff[AvgW]) begin
      step = (AvgW + 1)'($signed(diff + (AvgW + 1)'(3)) >>> 2);
    end else begin
      step = diff >> 2;
    end
    avg_sum = {1'b0, avg} + step;
    // An average of zero means unseeded, so the new rate is loaded as is.
    avg_next = (avg == '0) ? x16 : avg_sum[AvgW-1:0];
    rounded  = {1'b0, avg_next} + ROUND_HALF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avg <= '0;
    end else if (commit) begin
      avg <= avg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata <= {rr_q[IvW-1:0], iv, rounded[AvgW-1:4]};
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for heart_rate_from_beat_intervals: directed and random beat
// intervals, a transaction-level rate predictor and a stream scoreboard on the result side.
// Depends on hrbi_pkg and the heart_rate_from_beat_intervals RTL.
module tb;

  localparam int IvW = hrbi_pkg::IvW;
  localparam int BpmW = hrbi_pkg::BpmW;
  localparam int AvgW = hrbi_pkg::AvgW;

  localparam int unsigned MsPerMinute = 60000;
  localparam int unsigned RateCeiling = 250;
  localparam int HistDepth = 3;
  localparam int HoldCycles = 400;
  localparam int SettleCycles = 60;
  localparam int CycleLimit = 600000;
  localparam int PhaseBeats = 360;

  typedef struct packed {
    logic [IvW-1:0]  rr_units;
    logic [IvW-1:0]  last_interval_ms;
    logic [BpmW-1:0] heart_rate_bpm;
  } beat_result_t;

  typedef struct {
    logic [IvW-1:0] interval_ms;
    bit             after_drain;  // hold this beat back until every rate result is out
  } beat_stim_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            s_tvalid = 1'b0;
  logic            s_tready;
  logic [IvW-1:0]  s_tdata = '0;
  logic            m_tvalid;
  logic            m_tready = 1'b0;
  logic [39:0]     m_tdata;

  heart_rate_from_beat_intervals dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #6 clk = ~clk;

  beat_stim_t   pending_beats[$];
  beat_result_t expected_rates[$];

  // Predictor state: interval history, fill level, write slot and averaged rate x16.
  logic [IvW-1:0]  hist_ms[HistDepth];
  int unsigned     hist_fill = 0;
  int unsigned     hist_slot = 0;
  logic [AvgW-1:0] avg_rate_x16 = '0;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  bit          hold_go = 1'b0;
  logic        rx_hold = 1'b0;

  int unsigned mismatch_count = 0;
  int unsigned beats_sent = 0;
  int unsigned gap_markers = 0;
  int unsigned rates_checked = 0;
  int unsigned cycle_count = 0;
  logic [IvW-1:0] rhythm_ms = 16'd800;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Advance the predictor by one accepted interval and queue the rate result it causes.
  task automatic track_beat(input logic [IvW-1:0] iv);
    logic [IvW-1:0] lo, hi, basis;
    int unsigned    bpm, rr_full;
    int             x16, avg_i;
    beat_result_t   res;
    if (iv == '0) begin
      // Gap marker: restart the history, keep the average, no result.
      hist_fill = 0;
      hist_slot = 0;
      gap_markers++;
      return;
    end
    hist_ms[hist_slot] = iv;
    hist_slot = (hist_slot + 1) % HistDepth;
    if (hist_fill < HistDepth) hist_fill++;
    if (hist_fill == HistDepth) begin
      lo = (hist_ms[0] < hist_ms[1]) ? hist_ms[0] : hist_ms[1];
      hi = (hist_ms[0] < hist_ms[1]) ? hist_ms[1] : hist_ms[0];
      if (hist_ms[2] <= lo) basis = lo;
      else if (hist_ms[2] >= hi) basis = hi;
      else basis = hist_ms[2];
    end else begin
      basis = iv;
    end
    bpm = MsPerMinute / int'(basis);
    if (bpm > RateCeiling) bpm = RateCeiling;
    x16 = int'(bpm * 16);
    if (avg_rate_x16 == '0) begin
      avg_rate_x16 = AvgW'(x16);
    end else begin
      // Signed division here truncates toward zero, as the average requires.
      avg_i = int'(avg_rate_x16);
      avg_i = avg_i + (x16 - avg_i) / 4;
      avg_rate_x16 = AvgW'(avg_i);
    end
    rr_full = (int'(iv) * 1024) / 1000;
    res.heart_rate_bpm = BpmW'((int'(avg_rate_x16) + 8) >> 4);
    res.last_interval_ms = iv;
    res.rr_units = IvW'(rr_full);
    expected_rates.push_back(res);
  endtask

  // Mostly a drifting sinus rhythm with the odd ectopic beat, plus gaps, raw noise, short intervals and corner values.
  function automatic logic [IvW-1:0] random_interval();
    int unsigned pick;
    int          drift;
    pick = $urandom_range(99);
    if (pick < 6) return '0;
    if (pick < 74) begin
      drift = int'($urandom_range(60)) - 30;
      if (int'(rhythm_ms) + drift < 300 || int'(rhythm_ms) + drift > 2000) drift = -drift;
      rhythm_ms = IvW'(int'(rhythm_ms) + drift);
      if (pick < 10) return rhythm_ms >> 1;  // premature beat
      if (pick < 13) return rhythm_ms << 1;  // missed beat
      return rhythm_ms;
    end
    if (pick < 88) return IvW'($urandom_range(65535));
    if (pick < 93) return IvW'($urandom_range(100, 1));
    case ($urandom_range(7))
      0: return 16'd1;
      1: return 16'd239;
      2: return 16'd240;
      3: return 16'd241;
      4: return 16'd60000;
      5: return 16'd60001;
      6: return 16'd65534;
      default: return 16'd65535;
    endcase
  endfunction

  task automatic queue_random_beats(input int n, input bit drain_first);
    beat_stim_t b;
    for (int i = 0; i < n; i++) begin
      b.interval_ms = random_interval();
      b.after_drain = drain_first && (i == 0);
      pending_beats.push_back(b);
    end
  endtask

  task automatic wait_pending_sent();
    while (pending_beats.size() != 0) @(posedge clk);
  endtask

  // Sender: offers the oldest pending beat, holds it until accepted, idles at random.
  always @(posedge clk) begin : beat_driver
    bit holding;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      holding = s_tvalid;
      if (s_tvalid && s_tready) begin
        track_beat(s_tdata);
        void'(pending_beats.pop_front());
        beats_sent++;
        holding = 1'b0;
      end
      if (holding) begin
        s_tvalid <= 1'b1;
      end else if (pending_beats.size() != 0 &&
                   !(pending_beats[0].after_drain && expected_rates.size() != 0) &&
                   $urandom_range(99) >= tx_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata <= pending_beats[0].interval_ms;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: checks every result transfer against the oldest expected rate.
  always @(posedge clk) begin : rate_monitor
    beat_result_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_rates.size() == 0) begin
          report_mismatch("unexpected result, last_interval_ms", got.last_interval_ms, 0);
        end else begin
          want = expected_rates.pop_front();
          if (got.heart_rate_bpm !== want.heart_rate_bpm)
            report_mismatch("heart_rate_bpm", got.heart_rate_bpm, want.heart_rate_bpm);
          if (got.last_interval_ms !== want.last_interval_ms)
            report_mismatch("last_interval_ms", got.last_interval_ms,
                            want.last_interval_ms);
          if (got.rr_units !== want.rr_units)
            report_mismatch("rr_units", got.rr_units, want.rr_units);
        end
        rates_checked++;
      end
      m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Long receiver hold-off so the block backs up and stalls its input side.
  initial begin : rx_hold_off
    wait (hold_go);
    @(negedge clk);
    rx_hold = 1'b1;
    repeat (HoldCycles) @(negedge clk);
    rx_hold = 1'b0;
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    logic [IvW-1:0] directed[$];
    beat_stim_t     b;
    // Unseeded average with rate-zero intervals first, then clamps, ring wrap, gaps,
    // rr wrap-around and rising/falling medians.
    directed = '{16'd65535, 16'd60001, 16'd0, 16'd0, 16'd1000, 16'h5555, 16'hAAAA,
                 16'd0, 16'd1, 16'd2, 16'd240, 16'd241, 16'd500, 16'd0, 16'd60000,
                 16'd300, 16'd1200, 16'd800, 16'd857, 16'd65535, 16'd65535, 16'd65535,
                 16'd32768, 16'h7FFF, 16'd0};
    foreach (directed[i]) begin
      b.interval_ms = directed[i];
      b.after_drain = 1'b0;
      pending_beats.push_back(b);
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    wait_pending_sent();

    // Full rate on both sides, with a long receiver hold-off at the start.
    queue_random_beats(PhaseBeats, 1'b0);
    hold_go = 1'b1;
    wait_pending_sent();

    tx_idle_pct = 76;
    rx_stall_pct = 0;
    queue_random_beats(PhaseBeats, 1'b1);
    wait_pending_sent();

    tx_idle_pct = 0;
    rx_stall_pct = 76;
    queue_random_beats(PhaseBeats, 1'b0);
    wait_pending_sent();

    tx_idle_pct = 33;
    rx_stall_pct = 33;
    queue_random_beats(PhaseBeats, 1'b1);
    wait_pending_sent();

    while (expected_rates.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    $display("Run covered %0d intervals, %0d of them gap markers, and %0d rate results,",
             beats_sent, gap_markers, rates_checked);
    $display("under full rate, sender gaps, receiver stalls and a long output hold-off.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
